>>> hw/rtl/rbst_pkg.sv
// Shared constants and types for the ray box slab test.
package rbst_pkg;

	localparam int FRAC_BITS_DEF = 16;
	localparam int REG_W         = 31;
	localparam int CFG_IDX_W     = 2;
	localparam int NUM_W         = 48;
	localparam int QBITS         = 31;
	localparam int DIV_LAT       = QBITS + 2;
	localparam int LANE_LAT      = DIV_LAT + 3;
	localparam int NLANES        = 3;

	localparam logic [CFG_IDX_W-1:0] CFG_CELL_SIZE  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_NEAR_LIMIT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_FAR_LIMIT  = 2'd2;

	localparam logic [REG_W-1:0] CELL_SIZE_RST  = 31'd65536;
	localparam logic [REG_W-1:0] NEAR_LIMIT_RST = 31'd1;
	localparam logic [REG_W-1:0] FAR_LIMIT_RST  = 31'd655360000;

	localparam logic [7:0] PLANT_LO = 8'd26;
	localparam logic [7:0] PLANT_HI = 8'd31;

	typedef struct packed {
		logic signed [31:0] ts;
		logic signed [31:0] tb;
		logic               skip;
		logic               miss;
	} lane_res_t;

endpackage

>>> hw/rtl/rbst_div.sv
// Pipelined saturating fixed-point divider, one quotient bit per stage.
module rbst_div import rbst_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic                    clk,
	input  logic                    en,
	input  logic signed [NUM_W-1:0] n,
	input  logic signed [31:0]      d,
	output logic signed [31:0]      q
);

	localparam int NB = NUM_W + FRAC_BITS;
	localparam int TW = NB - QBITS;
	localparam int CW = (TW > 33) ? TW : 33;

	logic [NUM_W-1:0] an;
	logic [31:0]      ad;
	logic [NB-1:0]    nn;
	logic [TW-1:0]    top;
	logic [CW-1:0]    top_w;
	logic             ovf;

	logic [31:0]      rem [0:QBITS];
	logic [QBITS-1:0] low [0:QBITS];
	logic [QBITS-1:0] quo [0:QBITS];
	logic [31:0]      dv  [0:QBITS];
	logic             ng  [0:QBITS];
	logic             ov  [0:QBITS];
	logic [32:0]      mag;

	always_comb begin
		an    = n[NUM_W-1] ? NUM_W'(-n) : NUM_W'(n);
		ad    = d[31] ? 32'(-d) : 32'(d);
		nn    = {an, FRAC_BITS'(0)};
		top   = nn[NB-1:QBITS];
		top_w = CW'(top);
		ovf   = top_w >= CW'(ad);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem[0] <= top_w[31:0];
			low[0] <= nn[QBITS-1:0];
			quo[0] <= '0;
			dv[0]  <= ad;
			ng[0]  <= n[NUM_W-1] ^ d[31];
			ov[0]  <= ovf;
		end
	end

	for (genvar k = 0; k < QBITS; k++) begin : g_step
		logic [32:0] r2;
		logic        ge;

		always_comb begin
			r2 = {rem[k], low[k][QBITS-1-k]};
			ge = r2 >= {1'b0, dv[k]};
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem[k+1] <= ge ? 32'(r2 - {1'b0, dv[k]}) : r2[31:0];
				low[k+1] <= low[k];
				quo[k+1] <= quo[k] | (QBITS'(ge) << (QBITS-1-k));
				dv[k+1]  <= dv[k];
				ng[k+1]  <= ng[k];
				ov[k+1]  <= ov[k];
			end
		end
	end

	always_comb begin
		mag = ov[QBITS] ? {2'b01, 31'd0} : {2'b00, quo[QBITS]};
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (ng[QBITS])
				q <= 32'(-mag);
			else if (ov[QBITS])
				q <= 32'h7fff_ffff;
			else
				q <= {1'b0, quo[QBITS]};
		end
	end

endmodule

>>> hw/rtl/rbst_lane.sv
// One axis of the slab test: box bounds, entry and exit distances.
module rbst_lane import rbst_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic               clk,
	input  logic               en,
	input  logic signed [31:0] org,
	input  logic signed [31:0] dir,
	input  logic signed [15:0] cell_idx,
	input  logic [REG_W-1:0]   size,
	input  logic [REG_W-1:0]   lo_off,
	input  logic [REG_W-1:0]   hi_off,
	output lane_res_t          res
);

	logic signed [NUM_W-1:0] lo_s1;
	logic signed [31:0]      org_s1, dir_s1;
	logic [REG_W-1:0]        size_s1, lo_off_s1, hi_off_s1;

	logic signed [NUM_W-1:0] lo, hi, org_w;
	logic                    zero;

	logic signed [NUM_W-1:0] n0_s2, n1_s2;
	logic signed [31:0]      d_s2;
	logic                    zero_s2, miss_s2;

	logic                    zero_d [0:DIV_LAT-1];
	logic                    miss_d [0:DIV_LAT-1];
	logic signed [31:0]      t0, t1;

	always_ff @(posedge clk) begin
		if (en) begin
			lo_s1     <= NUM_W'(cell_idx * $signed({1'b0, size}));
			org_s1    <= org;
			dir_s1    <= dir;
			size_s1   <= size;
			lo_off_s1 <= lo_off;
			hi_off_s1 <= hi_off;
		end
	end

	always_comb begin
		org_w = NUM_W'(org_s1);
		lo    = lo_s1 + $signed(NUM_W'(lo_off_s1));
		hi    = lo_s1 + $signed(NUM_W'(size_s1)) - $signed(NUM_W'(hi_off_s1));
		zero  = dir_s1 == 32'sd0;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			n0_s2   <= lo - org_w;
			n1_s2   <= hi - org_w;
			d_s2    <= dir_s1;
			zero_s2 <= zero;
			miss_s2 <= zero && (org_w < lo || org_w > hi);
		end
	end

	rbst_div #(.FRAC_BITS(FRAC_BITS)) u_div0 (
		.clk (clk),
		.en  (en),
		.n   (n0_s2),
		.d   (d_s2),
		.q   (t0)
	);

	rbst_div #(.FRAC_BITS(FRAC_BITS)) u_div1 (
		.clk (clk),
		.en  (en),
		.n   (n1_s2),
		.d   (d_s2),
		.q   (t1)
	);

	always_ff @(posedge clk) begin
		if (en) begin
			zero_d[0] <= zero_s2;
			miss_d[0] <= miss_s2;
			for (int i = 1; i < DIV_LAT; i++) begin
				zero_d[i] <= zero_d[i-1];
				miss_d[i] <= miss_d[i-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res.ts   <= (t0 < t1) ? t0 : t1;
			res.tb   <= (t0 < t1) ? t1 : t0;
			res.skip <= zero_d[DIV_LAT-1];
			res.miss <= miss_d[DIV_LAT-1];
		end
	end

endmodule

>>> hw/rtl/rbst_merge.sv
// Combines the three axis results into the hit decision.
module rbst_merge import rbst_pkg::*; (
	input  lane_res_t        res [NLANES],
	input  logic [REG_W-1:0] near_limit,
	input  logic [REG_W-1:0] far_limit,
	output logic             hit
);

	logic signed [31:0] enter, leave;
	logic               miss;

	always_comb begin
		enter = $signed({1'b0, near_limit});
		leave = $signed({1'b0, far_limit});
		miss  = 1'b0;
		for (int i = 0; i < NLANES; i++) begin
			if (res[i].skip) begin
				miss = miss | res[i].miss;
			end else begin
				if (res[i].ts > enter)
					enter = res[i].ts;
				if (res[i].tb < leave)
					leave = res[i].tb;
			end
		end
		hit = !miss && (enter < leave);
	end

endmodule

>>> hw/rtl/ray_box_slab_test.sv
// Ray against grid-cell box slab test, top level.
//
// Input words arrive on s_axis: tdata carries the ray origin, direction and
// cell index, tuser the block kind. One output word per input word leaves on
// m_axis with the hit flag in tdata bit 0, in input order.
// Configuration: cfg_we with cfg_addr 0 = cell size, 1 = near limit,
// 2 = far limit; write only while no word is in flight.
// Pipeline: a word passes 37 register stages before m_axis_tvalid rises:
// two set-up stages, a 33-stage divider with one quotient bit per stage on
// each axis, a min/max stage and the output register.
// Throughput: one word per cycle while the receiver does not stall; the three
// axes run in parallel lanes, each with two pipelined dividers.
// Reset clears the pipeline valid bits and loads the register defaults
// (cell size 1.0, near limit 2^-16, far limit 10000.0).
// When the receiver stalls with a word waiting, the whole pipeline holds and
// s_axis_tready falls; nothing is dropped.
module ray_box_slab_test import rbst_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_axis_tvalid,
	output logic                 s_axis_tready,
	// origin_x, origin_y, origin_z, dir_x, dir_y, dir_z, cell_x, cell_y, cell_z
	input  logic [239:0]         s_axis_tdata,
	// block_kind
	input  logic [7:0]           s_axis_tuser,
	output logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	// hit, zero fill
	output logic [7:0]           m_axis_tdata,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_addr,
	input  logic [REG_W-1:0]     cfg_data
);

	logic [REG_W-1:0]  cell_size_q, near_limit_q, far_limit_q;
	logic              en;
	logic [LANE_LAT-1:0] v_q;
	logic              hit_q, hit;
	logic              plant;
	logic [REG_W-1:0]  quarter, half;
	logic [REG_W-1:0]  lo_off [NLANES];
	logic [REG_W-1:0]  hi_off [NLANES];
	lane_res_t         res [NLANES];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cell_size_q  <= CELL_SIZE_RST;
			near_limit_q <= NEAR_LIMIT_RST;
			far_limit_q  <= FAR_LIMIT_RST;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				CFG_CELL_SIZE:  cell_size_q  <= cfg_data;
				CFG_NEAR_LIMIT: near_limit_q <= cfg_data;
				CFG_FAR_LIMIT:  far_limit_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	assign en            = !m_axis_tvalid || m_axis_tready;
	assign s_axis_tready = en;

	always_comb begin
		plant     = s_axis_tuser >= PLANT_LO && s_axis_tuser <= PLANT_HI;
		quarter   = plant ? (cell_size_q >> 2) : '0;
		half      = REG_W'({quarter, 1'b0});
		lo_off[0] = quarter;
		hi_off[0] = quarter;
		lo_off[1] = '0;
		hi_off[1] = half;
		lo_off[2] = quarter;
		hi_off[2] = quarter;
	end

	for (genvar a = 0; a < NLANES; a++) begin : g_lane
		rbst_lane #(.FRAC_BITS(FRAC_BITS)) u_lane (
			.clk      (clk),
			.en       (en),
			.org      ($signed(s_axis_tdata[32*a +: 32])),
			.dir      ($signed(s_axis_tdata[96 + 32*a +: 32])),
			.cell_idx ($signed(s_axis_tdata[192 + 16*a +: 16])),
			.size     (cell_size_q),
			.lo_off   (lo_off[a]),
			.hi_off   (hi_off[a]),
			.res      (res[a])
		);
	end

	rbst_merge u_merge (
		.res        (res),
		.near_limit (near_limit_q),
		.far_limit  (far_limit_q),
		.hit        (hit)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q           <= '0;
			m_axis_tvalid <= 1'b0;
		end else if (en) begin
			v_q           <= {v_q[LANE_LAT-2:0], s_axis_tvalid};
			m_axis_tvalid <= v_q[LANE_LAT-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en)
			hit_q <= hit;
	end

	assign m_axis_tdata = {7'd0, hit_q};

endmodule

>>> test/ray_box_slab_test_tb.sv
// Self-checking testbench for the ray box slab test: directed and random rays against a predictor.
module testbench;
	import rbst_pkg::*;

	localparam int FB = FRAC_BITS_DEF;
	localparam int LAT = LANE_LAT + 1;
	localparam int WATCHDOG = 20000;

	typedef struct {
		logic signed [31:0] org [3];
		logic signed [31:0] dir [3];
		logic signed [15:0] cell_idx [3];
		logic [7:0]         kind;
	} ray_t;

	class hit_board;
		bit   pending[$];
		int   errors;
		logic [30:0] size_r, near_r, far_r;

		function new();
			errors = 0;
			size_r = CELL_SIZE_RST;
			near_r = NEAR_LIMIT_RST;
			far_r = FAR_LIMIT_RST;
		endfunction

		function longint slab_div(longint n, longint d);
			bit neg;
			longint an, ad, ip, rem, mag;
			neg = (n < 0) != (d < 0);
			an = (n < 0) ? -n : n;
			ad = (d < 0) ? -d : d;
			ip = an / ad;
			rem = an % ad;
			if (ip >= (64'sd1 <<< (31 - FB)))
				mag = 64'sd1 <<< 31;
			else
				mag = (ip <<< FB) + ((rem <<< FB) / ad);
			if (neg)
				return -mag;
			if (mag > 64'sh7FFFFFFF)
				mag = 64'sh7FFFFFFF;
			return mag;
		endfunction

		function bit ray_hits(ray_t r);
			longint lo[3], hi[3], sz, enter, leave, q, t0, t1, ts, tb;
			bit miss;
			sz = size_r;
			enter = near_r;
			leave = far_r;
			miss = 0;
			for (int i = 0; i < 3; i++) begin
				lo[i] = longint'(r.cell_idx[i]) * sz;
				hi[i] = lo[i] + sz;
			end
			if (r.kind >= PLANT_LO && r.kind <= PLANT_HI) begin
				q = sz >>> 2;
				lo[0] += q; lo[2] += q;
				hi[0] -= q; hi[1] -= 2 * q; hi[2] -= q;
			end
			for (int i = 0; i < 3; i++) begin
				if (r.dir[i] == 0) begin
					if (r.org[i] < lo[i] || r.org[i] > hi[i])
						miss = 1;
				end else begin
					t0 = slab_div(lo[i] - r.org[i], r.dir[i]);
					t1 = slab_div(hi[i] - r.org[i], r.dir[i]);
					ts = (t0 < t1) ? t0 : t1;
					tb = (t0 < t1) ? t1 : t0;
					if (ts > enter) enter = ts;
					if (tb < leave) leave = tb;
				end
			end
			return !miss && enter < leave;
		endfunction

		function void note_ray(ray_t r);
			pending.push_back(ray_hits(r));
		endfunction

		function void check_word(logic [7:0] w);
			bit e;
			if (pending.size() == 0) begin
				$error("unexpected output word %h", w);
				errors++;
				return;
			end
			e = pending.pop_front();
			if (w[0] !== e || w[7:1] !== 7'd0) begin
				$error("hit: expected %0d, got %0d (word %h)", e, w[0], w);
				errors++;
			end
		endfunction
	endclass

	logic clk = 0, arst_n = 0;
	logic s_axis_tvalid = 0, s_axis_tready, m_axis_tvalid, m_axis_tready = 0;
	logic [239:0] s_axis_tdata = '0;
	logic [7:0] s_axis_tuser = '0, m_axis_tdata;
	logic cfg_we = 0;
	logic [CFG_IDX_W-1:0] cfg_addr = '0;
	logic [REG_W-1:0] cfg_data = '0;

	hit_board board = new();
	int idle_cycles = 0, sent = 0, got = 0, hits = 0;
	bit hold_long = 0, done = 0;

	ray_box_slab_test i_dut (.*);

	initial forever #6 clk = ~clk;

	function int gap_len();
		int p;
		p = $urandom_range(0, 99);
		if (p < 55) return 0;
		if (p < 95) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	task automatic send_ray(ray_t r);
		int g;
		g = gap_len();
		if (g > 0) begin
			s_axis_tvalid <= 0;
			repeat (g) @(posedge clk);
		end
		s_axis_tvalid <= 1;
		s_axis_tdata <= {r.cell_idx[2], r.cell_idx[1], r.cell_idx[0],
			r.dir[2], r.dir[1], r.dir[0], r.org[2], r.org[1], r.org[0]};
		s_axis_tuser <= r.kind;
		do @(posedge clk); while (!s_axis_tready);
		board.note_ray(r);
		sent++;
	endtask

	task automatic drain();
		s_axis_tvalid <= 0;
		while (board.pending.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] a, logic [REG_W-1:0] v);
		drain();
		cfg_we <= 1; cfg_addr <= a; cfg_data <= v;
		@(posedge clk);
		cfg_we <= 0;
		case (a)
			CFG_CELL_SIZE:  board.size_r = v;
			CFG_NEAR_LIMIT: board.near_r = v;
			CFG_FAR_LIMIT:  board.far_r = v;
			default: ;
		endcase
	endtask

	function automatic logic [31:0] rand_edge32();
		case ($urandom_range(0, 5))
			0: return 32'h80000000;
			1: return 32'h7FFFFFFF;
			2: return 0;
			3: return $urandom_range(0, 3) - 1;
			default: return $urandom;
		endcase
	endfunction

	// mostly rays aimed near the target cell so hits are frequent
	function automatic ray_t aimed_ray(bit wild);
		ray_t r;
		int sz;
		sz = board.size_r;
		for (int i = 0; i < 3; i++) begin
			r.cell_idx[i] = wild ? 16'($urandom) : 16'($urandom_range(0, 8) - 4);
			if (wild) begin
				r.org[i] = rand_edge32();
				r.dir[i] = rand_edge32();
			end else begin
				r.org[i] = r.cell_idx[i] * sz + $urandom_range(0, 8 * sz) - 4 * sz;
				r.dir[i] = ($urandom_range(0, 7) == 0) ? 0 :
					$signed($urandom_range(0, 4 << FB)) - (2 << FB);
			end
		end
		r.kind = ($urandom_range(0, 2) == 0) ? 8'($urandom_range(PLANT_LO, PLANT_HI))
			: 8'($urandom);
		return r;
	endfunction

	task automatic random_phase(int n);
		for (int k = 0; k < n; k++)
			send_ray(aimed_ray($urandom_range(0, 4) == 0));
	endtask

	initial begin
		ray_t r;
		repeat (12) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		// directed: axis-aligned rays, plants, zero directions, extremes
		for (int k = 0; k < 20; k++) begin
			for (int i = 0; i < 3; i++) begin
				r.cell_idx[i] = 0;
				r.org[i] = 32'sh8000;
				r.dir[i] = 0;
			end
			r.kind = (k % 2) ? 8'(PLANT_LO + k % 6) : 8'(k);
			case (k % 10)
				0: begin r.org[0] = -(2 << FB); r.dir[0] = 1 << FB; end
				1: begin r.org[1] = 5 << FB; r.dir[1] = -(1 << FB); end
				2: r.org[2] = 3 << FB;
				3: begin r.dir = '{32'h7FFFFFFF, 32'h80000000, 1}; end
				4: begin r.org = '{32'h80000000, 32'h7FFFFFFF, 0}; r.dir[0] = 1; end
				5: begin r.cell_idx = '{16'h8000, 16'h7FFF, 16'hFFFF}; r.dir[2] = 1; end
				6: begin r.org[0] = 32'sh4000; r.org[1] = 32'shC000; r.dir[2] = 1 << FB; end
				7: begin r.org[2] = 32'sh3FFF; r.dir[0] = 1; end
				8: begin r.dir = '{-1, -1, -1}; r.kind = 8'hFF; end
				default: r.dir = '{1 << FB, 1 << FB, 1 << FB};
			endcase
			send_ray(r);
		end
		random_phase(150);
		// receiver holds off while the sender keeps offering
		hold_long = 1;
		random_phase(80);
		drain();
		write_reg(CFG_CELL_SIZE, 1);
		write_reg(CFG_NEAR_LIMIT, 0);
		write_reg(CFG_FAR_LIMIT, 31'h7FFFFFFF);
		random_phase(180);
		write_reg(CFG_CELL_SIZE, 31'h7FFFFFFF);
		random_phase(180);
		write_reg(CFG_CELL_SIZE, 0);
		write_reg(CFG_FAR_LIMIT, 0);
		random_phase(80);
		write_reg(CFG_CELL_SIZE, REG_W'(3 << FB));
		write_reg(CFG_NEAR_LIMIT, 31'h7FFFFFFF);
		random_phase(80);
		write_reg(CFG_CELL_SIZE, REG_W'(1000 + $urandom_range(0, 200000)));
		write_reg(CFG_NEAR_LIMIT, REG_W'($urandom_range(0, 1 << FB)));
		write_reg(CFG_FAR_LIMIT, REG_W'($urandom_range(1 << FB, 100 << FB)));
		random_phase(380);
		drain();
		repeat (LAT + 10) @(posedge clk);
		done = 1;
	end

	initial begin
		int stretch;
		@(posedge arst_n);
		forever begin
			if (hold_long) begin
				hold_long = 0;
				m_axis_tready <= 0;
				stretch = 4 * LAT;
				repeat (stretch) @(posedge clk);
			end
			if ($urandom_range(0, 40) == 0) begin
				m_axis_tready <= 0;
				repeat ($urandom_range(10, 30)) @(posedge clk);
				m_axis_tready <= 1;
			end else begin
				m_axis_tready <= ($urandom_range(0, 3) != 0);
			end
			@(posedge clk);
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			board.check_word(m_axis_tdata);
			got++;
			hits += m_axis_tdata[0];
		end
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
	end

	initial begin
		wait (done || idle_cycles >= WATCHDOG);
		if (!done) begin
			$display("watchdog expired with %0d words outstanding", board.pending.size());
			$display("FAILURE");
			$finish;
		end
		$display("Checked %0d rays (%0d hits) over six register settings incl. extremes.",
			got, hits);
		if (board.errors == 0 && board.pending.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

>>> files.f
hw/rtl/rbst_pkg.sv
hw/rtl/rbst_div.sv
hw/rtl/rbst_lane.sv
hw/rtl/rbst_merge.sv
hw/rtl/ray_box_slab_test.sv
test/ray_box_slab_test_tb.sv
